// File: sv/fbc_pkg.sv
// Shared constants, types and helpers for the frustum box cull test block.
// Used by fbc_world and frustum_box_cull_test_core; depends on nothing.
`default_nettype none
package fbc_pkg;

    localparam int FRAC_BITS  = 8;
    localparam int NUM_PLANES = 6;
    localparam int LANE_W     = 16;
    localparam int WORD_W     = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int SUM_W      = LANE_W + 1;
    localparam int CPROD_W    = LANE_W + SUM_W;
    localparam int HPROD_W    = 2 * SUM_W;
    localparam int W_W        = 36;
    localparam int PROD_W     = LANE_W + W_W;
    localparam int DIST_W     = 56;

    localparam logic [CFG_IDX_W-1:0] REG_PLANE_LEFT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_RIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_BOTTOM = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_TOP    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_NEAR   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_FAR    = 3'd5;

    localparam logic [1:0] LANE_X     = 2'd0;
    localparam logic [1:0] LANE_Y     = 2'd1;
    localparam logic [1:0] LANE_Z     = 2'd2;
    localparam logic [1:0] LANE_CONST = 2'd3;

    typedef logic signed [LANE_W-1:0] t_lane;
    typedef logic signed [W_W-1:0]    t_wcoord;

    typedef struct packed {
        logic                   valid;
        logic                   invalid;
        logic [2:0][W_W-1:0]    wmin;
        logic [2:0][W_W-1:0]    wmax;
    } t_world;

    function automatic t_lane lane(input logic [WORD_W-1:0] w, input logic [1:0] k);
        return t_lane'(w[LANE_W*k +: LANE_W]);
    endfunction

endpackage
`default_nettype wire

// File: sv/fbc_world.sv
// Three-stage transform of an object-space box into a doubled world-space box.
// Depends on fbc_pkg for widths, lane extraction and the t_world bundle.
`default_nettype none
module fbc_world (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_valid,
    input  wire fbc_pkg::t_lane                     i_lo [3],
    input  wire fbc_pkg::t_lane                     i_hi [3],
    input  wire logic [fbc_pkg::WORD_W-1:0]         i_row [3],
    output fbc_pkg::t_world                         o_world
);

    logic                                   r_a_valid;
    logic                                   r_a_invalid;
    logic signed [fbc_pkg::SUM_W-1:0]       r_a_c2 [3];
    logic signed [fbc_pkg::SUM_W-1:0]       r_a_h2 [3];
    fbc_pkg::t_lane                         r_a_m  [3][3];
    fbc_pkg::t_lane                         r_a_t  [3];

    logic                                   r_b_valid;
    logic                                   r_b_invalid;
    logic signed [fbc_pkg::CPROD_W-1:0]     r_b_cp [3][3];
    logic signed [fbc_pkg::HPROD_W-1:0]     r_b_hp [3][3];
    fbc_pkg::t_wcoord                       r_b_t  [3];

    logic                                   n_a_invalid;
    logic signed [fbc_pkg::SUM_W-1:0]       n_abs  [3][3];
    fbc_pkg::t_wcoord                       n_centre [3];
    fbc_pkg::t_wcoord                       n_half   [3];
    fbc_pkg::t_world                        r_c;

    always_comb begin
        n_a_invalid = 1'b0;
        for (int k = 0; k < 3; k++) begin
            if (i_lo[k] > i_hi[k]) begin
                n_a_invalid = 1'b1;
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                n_abs[i][j] = r_a_m[i][j][fbc_pkg::LANE_W-1]
                    ? -$signed({1'b1, r_a_m[i][j]})
                    : $signed({1'b0, r_a_m[i][j]});
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_centre[i] = r_b_t[i];
            n_half[i]   = '0;
            for (int j = 0; j < 3; j++) begin
                n_centre[i] = n_centre[i] + fbc_pkg::W_W'(r_b_cp[i][j]);
                n_half[i]   = n_half[i] + fbc_pkg::W_W'(r_b_hp[i][j]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_invalid <= n_a_invalid;
        for (int k = 0; k < 3; k++) begin
            r_a_c2[k] <= fbc_pkg::SUM_W'(i_lo[k]) + fbc_pkg::SUM_W'(i_hi[k]);
            r_a_h2[k] <= fbc_pkg::SUM_W'(i_hi[k]) - fbc_pkg::SUM_W'(i_lo[k]);
            r_a_t[k]  <= fbc_pkg::lane(i_row[k], fbc_pkg::LANE_CONST);
            r_a_m[k][0] <= fbc_pkg::lane(i_row[k], fbc_pkg::LANE_X);
            r_a_m[k][1] <= fbc_pkg::lane(i_row[k], fbc_pkg::LANE_Y);
            r_a_m[k][2] <= fbc_pkg::lane(i_row[k], fbc_pkg::LANE_Z);
        end

        r_b_invalid <= r_a_invalid;
        for (int i = 0; i < 3; i++) begin
            r_b_t[i] <= fbc_pkg::W_W'(r_a_t[i]) <<< (fbc_pkg::FRAC_BITS + 1);
            for (int j = 0; j < 3; j++) begin
                r_b_cp[i][j] <= fbc_pkg::CPROD_W'(r_a_m[i][j]) *
                                fbc_pkg::CPROD_W'(r_a_c2[j]);
                r_b_hp[i][j] <= fbc_pkg::HPROD_W'(n_abs[i][j]) *
                                fbc_pkg::HPROD_W'(r_a_h2[j]);
            end
        end

        r_c.invalid <= r_b_invalid;
        for (int i = 0; i < 3; i++) begin
            r_c.wmin[i] <= n_centre[i] - n_half[i];
            r_c.wmax[i] <= n_centre[i] + n_half[i];
        end

        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c.valid <= 1'b0;
        end else begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
            r_c.valid <= r_b_valid;
        end
    end

    assign o_world = r_c;

`ifndef SYNTH
    a_world_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_c.valid && !r_c.invalid) |->
            ($signed(r_c.wmax[0]) >= $signed(r_c.wmin[0])) &&
            ($signed(r_c.wmax[1]) >= $signed(r_c.wmin[1])) &&
            ($signed(r_c.wmax[2]) >= $signed(r_c.wmin[2])))
        else $error("world box has max below min for a valid box");

    a_world_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> ##3 r_c.valid)
        else $error("world stage lost a transfer");

    a_world_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_c.valid |-> $past(i_valid && i_rst_n, 3))
        else $error("world stage produced an unrequested transfer");
`endif

endmodule
`default_nettype wire

// File: sv/frustum_box_cull_test_core.sv
// Frustum culling of an object-space box: top level with plane registers and
// the plane test stages. Depends on fbc_pkg and fbc_world.
//
// Usage: an item is a box (min and max corners) and three model matrix rows.
// It is transferred at a rising edge where i_start is high and o_busy is low;
// o_busy is always low, so one box can be transferred in every cycle.
// The pipeline has five register stages: box sums, matrix products, world
// corners, plane products, and the distance sums with the final decision.
// The result leaves the last stage with o_done high for exactly one cycle and
// o_visible and o_box_invalid alongside it. Throughput is one box per cycle,
// set by the fully pipelined multiplier stages.
// The receiver cannot hold results off; every result is shown once.
// Plane registers are written through i_cfg_we, i_cfg_idx and i_cfg_data and
// should change only while no box is in flight. Reset clears all planes to
// zero and empties the pipeline; with zero planes every valid box is visible.
`default_nettype none
module frustum_box_cull_test_core (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_start,
    output logic                                       o_busy,
    input  wire logic                                  i_cfg_we,
    input  wire logic [fbc_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  wire logic [fbc_pkg::WORD_W-1:0]            i_cfg_data,
    input  wire logic signed [fbc_pkg::LANE_W-1:0]     i_local_min_x,
    input  wire logic signed [fbc_pkg::LANE_W-1:0]     i_local_min_y,
    input  wire logic signed [fbc_pkg::LANE_W-1:0]     i_local_min_z,
    input  wire logic signed [fbc_pkg::LANE_W-1:0]     i_local_max_x,
    input  wire logic signed [fbc_pkg::LANE_W-1:0]     i_local_max_y,
    input  wire logic signed [fbc_pkg::LANE_W-1:0]     i_local_max_z,
    input  wire logic [fbc_pkg::WORD_W-1:0]            i_model_row_x,
    input  wire logic [fbc_pkg::WORD_W-1:0]            i_model_row_y,
    input  wire logic [fbc_pkg::WORD_W-1:0]            i_model_row_z,
    output logic                                       o_done,
    output logic                                       o_visible,
    output logic                                       o_box_invalid
);

    logic [fbc_pkg::WORD_W-1:0]             r_plane [fbc_pkg::NUM_PLANES];

    fbc_pkg::t_lane                         lo  [3];
    fbc_pkg::t_lane                         hi  [3];
    logic [fbc_pkg::WORD_W-1:0]             row [3];
    fbc_pkg::t_world                        world;

    logic                                   r_d_valid;
    logic                                   r_d_invalid;
    logic signed [fbc_pkg::PROD_W-1:0]      r_d_prod  [fbc_pkg::NUM_PLANES][3];
    logic signed [fbc_pkg::DIST_W-1:0]      r_d_dterm [fbc_pkg::NUM_PLANES];

    fbc_pkg::t_lane                         n_norm [fbc_pkg::NUM_PLANES][3];
    fbc_pkg::t_wcoord                       n_vert [fbc_pkg::NUM_PLANES][3];
    logic signed [fbc_pkg::DIST_W-1:0]      n_dist [fbc_pkg::NUM_PLANES];
    logic                                   n_cull;
    logic                                   accept;

    assign o_busy = 1'b0;
    assign accept = i_start && !o_busy;

    assign lo[0]  = i_local_min_x;
    assign lo[1]  = i_local_min_y;
    assign lo[2]  = i_local_min_z;
    assign hi[0]  = i_local_max_x;
    assign hi[1]  = i_local_max_y;
    assign hi[2]  = i_local_max_z;
    assign row[0] = i_model_row_x;
    assign row[1] = i_model_row_y;
    assign row[2] = i_model_row_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < fbc_pkg::NUM_PLANES; p++) begin
                r_plane[p] <= '0;
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                fbc_pkg::REG_PLANE_LEFT:   r_plane[0] <= i_cfg_data;
                fbc_pkg::REG_PLANE_RIGHT:  r_plane[1] <= i_cfg_data;
                fbc_pkg::REG_PLANE_BOTTOM: r_plane[2] <= i_cfg_data;
                fbc_pkg::REG_PLANE_TOP:    r_plane[3] <= i_cfg_data;
                fbc_pkg::REG_PLANE_NEAR:   r_plane[4] <= i_cfg_data;
                fbc_pkg::REG_PLANE_FAR:    r_plane[5] <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    fbc_world u_world (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_lo    (lo),
        .i_hi    (hi),
        .i_row   (row),
        .o_world (world)
    );

    // The positive vertex takes the max corner where the normal component is
    // zero or positive, and the min corner where it is negative.
    always_comb begin
        for (int p = 0; p < fbc_pkg::NUM_PLANES; p++) begin
            n_norm[p][0] = fbc_pkg::lane(r_plane[p], fbc_pkg::LANE_X);
            n_norm[p][1] = fbc_pkg::lane(r_plane[p], fbc_pkg::LANE_Y);
            n_norm[p][2] = fbc_pkg::lane(r_plane[p], fbc_pkg::LANE_Z);
            for (int j = 0; j < 3; j++) begin
                n_vert[p][j] = n_norm[p][j][fbc_pkg::LANE_W-1]
                    ? $signed(world.wmin[j]) : $signed(world.wmax[j]);
            end
        end
    end

    always_comb begin
        n_cull = 1'b0;
        for (int p = 0; p < fbc_pkg::NUM_PLANES; p++) begin
            n_dist[p] = r_d_dterm[p];
            for (int j = 0; j < 3; j++) begin
                n_dist[p] = n_dist[p] + fbc_pkg::DIST_W'(r_d_prod[p][j]);
            end
            if (n_dist[p][fbc_pkg::DIST_W-1]) begin
                n_cull = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
            o_done    <= 1'b0;
        end else begin
            r_d_valid <= world.valid;
            o_done    <= r_d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d_invalid <= world.invalid;
        for (int p = 0; p < fbc_pkg::NUM_PLANES; p++) begin
            r_d_dterm[p] <= fbc_pkg::DIST_W'(
                fbc_pkg::lane(r_plane[p], fbc_pkg::LANE_CONST))
                <<< (2 * fbc_pkg::FRAC_BITS + 1);
            for (int j = 0; j < 3; j++) begin
                r_d_prod[p][j] <= fbc_pkg::PROD_W'(n_norm[p][j]) *
                                  fbc_pkg::PROD_W'(n_vert[p][j]);
            end
        end
        o_box_invalid <= r_d_invalid;
        o_visible     <= r_d_invalid || !n_cull;
    end

`ifndef SYNTH
    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##5 o_done)
        else $error("accepted box produced no result");

    a_result_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(i_start && i_rst_n, 5))
        else $error("result without a matching accepted box");

    a_invalid_visible: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_box_invalid) |-> o_visible)
        else $error("invalid box was culled");
`endif

endmodule
`default_nettype wire

// File: dv/fbc_cull_checker.sv
`timescale 1ns / 100ps
// Scoreboard for frustum_box_cull_test_core: mirrors the plane registers, predicts the
// verdict of every box transfer and compares it with the result strobe, oldest first.
// Depends on fbc_pkg for widths and the plane count.
module fbc_cull_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic                              i_busy,
    input  logic                              i_cfg_we,
    input  logic [fbc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [fbc_pkg::WORD_W-1:0]        i_cfg_data,
    input  logic [fbc_pkg::LANE_W-1:0]        i_local_min_x,
    input  logic [fbc_pkg::LANE_W-1:0]        i_local_min_y,
    input  logic [fbc_pkg::LANE_W-1:0]        i_local_min_z,
    input  logic [fbc_pkg::LANE_W-1:0]        i_local_max_x,
    input  logic [fbc_pkg::LANE_W-1:0]        i_local_max_y,
    input  logic [fbc_pkg::LANE_W-1:0]        i_local_max_z,
    input  logic [fbc_pkg::WORD_W-1:0]        i_model_row_x,
    input  logic [fbc_pkg::WORD_W-1:0]        i_model_row_y,
    input  logic [fbc_pkg::WORD_W-1:0]        i_model_row_z,
    input  logic                              i_done,
    input  logic                              i_visible,
    input  logic                              i_box_invalid,
    output int                                o_fail_count,
    output int                                o_outstanding
);

    localparam longint UNIT = longint'(1) << fbc_pkg::FRAC_BITS;

    typedef struct packed {
        logic [2:0][fbc_pkg::LANE_W-1:0] lo;
        logic [2:0][fbc_pkg::LANE_W-1:0] hi;
        logic [2:0][fbc_pkg::WORD_W-1:0] row;
    } box_obs_t;

    typedef struct packed {
        logic visible;
        logic box_invalid;
    } verdict_t;

    verdict_t                   verdicts_due[$];
    verdict_t                   oldest;
    logic [fbc_pkg::WORD_W-1:0] planes_mirror [fbc_pkg::NUM_PLANES];
    int                         mismatches = 0;

    function automatic longint lane_value(input logic [fbc_pkg::WORD_W-1:0] word, input int k);
        return longint'($signed(word[k*fbc_pkg::LANE_W +: fbc_pkg::LANE_W]));
    endfunction

    // World corners are kept doubled so that the half extent never rounds.
    function automatic verdict_t predict_verdict(input box_obs_t b);
        longint lo;
        longint hi;
        longint sum2 [3];
        longint span2 [3];
        longint world_lo [3];
        longint world_hi [3];
        longint ctr;
        longint spread;
        longint plane_dist;
        longint m;
        longint n;
        int     i;
        int     j;
        for (i = 0; i < 3; i++) begin
            lo = longint'($signed(b.lo[i]));
            hi = longint'($signed(b.hi[i]));
            if (lo > hi) begin
                return '{visible: 1'b1, box_invalid: 1'b1};
            end
            sum2[i]  = lo + hi;
            span2[i] = hi - lo;
        end
        for (i = 0; i < 3; i++) begin
            ctr    = lane_value(b.row[i], 3) * 2 * UNIT;
            spread = 0;
            for (j = 0; j < 3; j++) begin
                m = lane_value(b.row[i], j);
                ctr    += m * sum2[j];
                spread += (m < 0 ? -m : m) * span2[j];
            end
            world_lo[i] = ctr - spread;
            world_hi[i] = ctr + spread;
        end
        for (i = 0; i < fbc_pkg::NUM_PLANES; i++) begin
            plane_dist = lane_value(planes_mirror[i], 3) * 2 * UNIT * UNIT;
            for (j = 0; j < 3; j++) begin
                n = lane_value(planes_mirror[i], j);
                plane_dist += n * (n >= 0 ? world_hi[j] : world_lo[j]);
            end
            if (plane_dist < 0) begin
                return '{visible: 1'b0, box_invalid: 1'b0};
            end
        end
        return '{visible: 1'b1, box_invalid: 1'b0};
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            verdicts_due.delete();
            foreach (planes_mirror[p]) planes_mirror[p] = '0;
        end else begin
            if (i_done) begin
                if (verdicts_due.size() == 0) begin
                    $display("%0t: result with none expected: visible=%0b box_invalid=%0b",
                             $time, i_visible, i_box_invalid);
                    mismatches++;
                end else begin
                    oldest = verdicts_due.pop_front();
                    if (i_visible !== oldest.visible) begin
                        $display("%0t: visible mismatch: expected %0b, actual %0b",
                                 $time, oldest.visible, i_visible);
                        mismatches++;
                    end
                    if (i_box_invalid !== oldest.box_invalid) begin
                        $display("%0t: box_invalid mismatch: expected %0b, actual %0b",
                                 $time, oldest.box_invalid, i_box_invalid);
                        mismatches++;
                    end
                end
            end
            if (i_cfg_we && i_cfg_idx < fbc_pkg::NUM_PLANES) begin
                planes_mirror[i_cfg_idx] = i_cfg_data;
            end
            if (i_start && !i_busy) begin
                verdicts_due.push_back(predict_verdict('{
                    lo:  {i_local_min_z, i_local_min_y, i_local_min_x},
                    hi:  {i_local_max_z, i_local_max_y, i_local_max_x},
                    row: {i_model_row_z, i_model_row_y, i_model_row_x}}));
            end
        end
        o_outstanding <= verdicts_due.size();
        o_fail_count  <= mismatches;
    end

endmodule

// File: dv/tb_frustum_box_cull_test_core.sv
`timescale 1ns / 100ps
// Testbench top for frustum_box_cull_test_core: drives box transfers and plane writes,
// and gives the verdict. Depends on fbc_pkg, the core and fbc_cull_checker.
module tb_frustum_box_cull_test_core;

    localparam int STALL_LIMIT     = 1000;
    localparam int DRAIN_CYCLES    = 8;
    localparam int ITEMS_PER_PHASE = 300;

    localparam logic [63:0] ROW_IDENT_X = {16'h0000, 16'h0000, 16'h0000, 16'h0100};
    localparam logic [63:0] ROW_IDENT_Y = {16'h0000, 16'h0000, 16'h0100, 16'h0000};
    localparam logic [63:0] ROW_IDENT_Z = {16'h0000, 16'h0100, 16'h0000, 16'h0000};

    typedef enum {PLANES_ZERO, PLANES_FRUSTUM, PLANES_RANDOM, PLANES_EXTREME} plane_mode_t;

    typedef struct packed {
        logic [2:0][15:0] lo;
        logic [2:0][15:0] hi;
        logic [2:0][63:0] row;
    } box_item_t;

    logic                               i_clk;
    logic                               i_rst_n;
    logic                               i_start;
    logic                               i_cfg_we;
    logic [fbc_pkg::CFG_IDX_W-1:0]      i_cfg_idx;
    logic [fbc_pkg::WORD_W-1:0]         i_cfg_data;
    logic signed [fbc_pkg::LANE_W-1:0]  i_local_min_x;
    logic signed [fbc_pkg::LANE_W-1:0]  i_local_min_y;
    logic signed [fbc_pkg::LANE_W-1:0]  i_local_min_z;
    logic signed [fbc_pkg::LANE_W-1:0]  i_local_max_x;
    logic signed [fbc_pkg::LANE_W-1:0]  i_local_max_y;
    logic signed [fbc_pkg::LANE_W-1:0]  i_local_max_z;
    logic [fbc_pkg::WORD_W-1:0]         i_model_row_x;
    logic [fbc_pkg::WORD_W-1:0]         i_model_row_y;
    logic [fbc_pkg::WORD_W-1:0]         i_model_row_z;
    logic                               o_busy;
    logic                               o_done;
    logic                               o_visible;
    logic                               o_box_invalid;
    int                                 fail_count;
    int                                 outstanding;
    int                                 idle_cycles;

    frustum_box_cull_test_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_start),
        .o_busy        (o_busy),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_local_min_x (i_local_min_x),
        .i_local_min_y (i_local_min_y),
        .i_local_min_z (i_local_min_z),
        .i_local_max_x (i_local_max_x),
        .i_local_max_y (i_local_max_y),
        .i_local_max_z (i_local_max_z),
        .i_model_row_x (i_model_row_x),
        .i_model_row_y (i_model_row_y),
        .i_model_row_z (i_model_row_z),
        .o_done        (o_done),
        .o_visible     (o_visible),
        .o_box_invalid (o_box_invalid)
    );

    fbc_cull_checker cull_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_start),
        .i_busy        (o_busy),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_local_min_x (i_local_min_x),
        .i_local_min_y (i_local_min_y),
        .i_local_min_z (i_local_min_z),
        .i_local_max_x (i_local_max_x),
        .i_local_max_y (i_local_max_y),
        .i_local_max_z (i_local_max_z),
        .i_model_row_x (i_model_row_x),
        .i_model_row_y (i_model_row_y),
        .i_model_row_z (i_model_row_z),
        .i_done        (o_done),
        .i_visible     (o_visible),
        .i_box_invalid (o_box_invalid),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_start && !o_busy) || o_done || i_cfg_we) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("frustum_box_cull_test_core regression: fail");
        $finish;
    end

    function automatic logic [63:0] pack_lanes(input logic [15:0] a, b, c, d);
        return {d, c, b, a};
    endfunction

    function automatic logic [63:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [15:0] rand_between(input int lo, input int hi);
        return 16'(int'($urandom_range(hi - lo)) + lo);
    endfunction

    function automatic box_item_t build_box(input logic [15:0] lx, ly, lz, hx, hy, hz,
                                            input logic [63:0] rx, ry, rz);
        return '{lo: {lz, ly, lx}, hi: {hz, hy, hx}, row: {rz, ry, rx}};
    endfunction

    // Frustum planes face inward in pairs: left/right on x, bottom/top on y, near/far on z.
    function automatic logic [63:0] gen_plane(input plane_mode_t mode, input int idx);
        logic [3:0][15:0] lanes;
        int               k;
        case (mode)
            PLANES_ZERO: begin
                lanes = '0;
            end
            PLANES_RANDOM: begin
                lanes = rand_word();
            end
            PLANES_EXTREME: begin
                for (k = 0; k < 4; k++) begin
                    case ($urandom_range(4))
                        0:       lanes[k] = 16'h8000;
                        1:       lanes[k] = 16'h7FFF;
                        2:       lanes[k] = 16'h0000;
                        3:       lanes[k] = 16'hFFFF;
                        default: lanes[k] = 16'h0001;
                    endcase
                end
            end
            default: begin
                for (k = 0; k < 3; k++) begin
                    if (k == idx / 2) begin
                        lanes[k] = rand_between(64, 512);
                        if (idx % 2 == 1) lanes[k] = -lanes[k];
                    end else begin
                        lanes[k] = rand_between(-64, 64);
                    end
                end
                lanes[3] = rand_between(-1024, 16384);
            end
        endcase
        return lanes;
    endfunction

    // Mostly well-formed boxes under plausible transforms, with invalid boxes and noise.
    function automatic box_item_t make_box();
        box_item_t        b;
        logic [3:0][15:0] lanes;
        int               pick;
        int               ax;
        int               a0;
        int               a1;
        int               centre;
        int               half;
        int               i;
        pick = $urandom_range(99);
        if (pick < 10) begin
            b.lo  = 48'({$urandom, $urandom});
            b.hi  = 48'({$urandom, $urandom});
            b.row = {rand_word(), rand_word(), rand_word()};
            return b;
        end
        for (ax = 0; ax < 3; ax++) begin
            if ($urandom_range(3) == 0) begin
                a0 = $signed(rand_between(-32768, 32767));
                a1 = $signed(rand_between(-32768, 32767));
            end else begin
                centre = $signed(rand_between(-8192, 8192));
                half   = $urandom_range(4096);
                a0     = centre - half;
                a1     = centre + half;
            end
            if (a0 > a1) begin
                b.lo[ax] = 16'(a1);
                b.hi[ax] = 16'(a0);
            end else begin
                b.lo[ax] = 16'(a0);
                b.hi[ax] = 16'(a1);
            end
        end
        if (pick < 20) begin
            ax = $urandom_range(2);
            if (b.lo[ax] == b.hi[ax]) begin
                if (b.lo[ax] == 16'h8000) b.lo[ax] = 16'h8001;
                else                      b.hi[ax] = b.hi[ax] - 16'd1;
            end else begin
                {b.lo[ax], b.hi[ax]} = {b.hi[ax], b.lo[ax]};
            end
        end
        for (i = 0; i < 3; i++) begin
            if ($urandom_range(9) < 3) begin
                b.row[i] = rand_word();
            end else begin
                for (ax = 0; ax < 3; ax++) begin
                    lanes[ax] = (ax == i) ? rand_between(-512, 512) : rand_between(-128, 128);
                end
                lanes[3] = rand_between(-16384, 16384);
                b.row[i] = lanes;
            end
        end
        return b;
    endfunction

    task automatic send_box(input box_item_t b);
        i_local_min_x = b.lo[0];
        i_local_min_y = b.lo[1];
        i_local_min_z = b.lo[2];
        i_local_max_x = b.hi[0];
        i_local_max_y = b.hi[1];
        i_local_max_z = b.hi[2];
        i_model_row_x = b.row[0];
        i_model_row_y = b.row[1];
        i_model_row_z = b.row[2];
        i_start       = 1'b1;
        do @(posedge i_clk); while (o_busy);
        @(negedge i_clk);
    endtask

    task automatic hold_idle(input int cycles);
        i_start = 1'b0;
        repeat (cycles) @(negedge i_clk);
    endtask

    task automatic drain_results();
        i_start = 1'b0;
        while (outstanding != 0) @(negedge i_clk);
    endtask

    task automatic write_plane(input logic [fbc_pkg::CFG_IDX_W-1:0] idx, input logic [63:0] data);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
    endtask

    task automatic load_planes(input plane_mode_t mode);
        int p;
        drain_results();
        for (p = 0; p < fbc_pkg::NUM_PLANES; p++) begin
            write_plane(fbc_pkg::CFG_IDX_W'(p), gen_plane(mode, p));
        end
    endtask

    task automatic run_random(input plane_mode_t mode, input bit steady);
        int n;
        load_planes(mode);
        for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (!steady && $urandom_range(99) < 12) hold_idle($urandom_range(1, 3));
            if (!steady && n == ITEMS_PER_PHASE / 2) drain_results();
            send_box(make_box());
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_start       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = '0;
        i_cfg_data    = '0;
        i_local_min_x = '0;
        i_local_min_y = '0;
        i_local_min_z = '0;
        i_local_max_x = '0;
        i_local_max_y = '0;
        i_local_max_z = '0;
        i_model_row_x = '0;
        i_model_row_y = '0;
        i_model_row_z = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        // With every plane at zero each valid box is visible.
        send_box(build_box('0, '0, '0, '0, '0, '0, ROW_IDENT_X, ROW_IDENT_Y, ROW_IDENT_Z));
        send_box(build_box(16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                           {4{16'h8000}}, {4{16'h8000}}, {4{16'h8000}}));
        send_box(build_box(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                           {4{16'h7FFF}}, {4{16'h7FFF}}, {4{16'h7FFF}}));
        send_box(build_box(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                           {4{16'hFFFF}}, {4{16'hFFFF}}, {4{16'hFFFF}}));
        send_box(build_box(16'd1, '0, '0, '0, '0, '0, ROW_IDENT_X, ROW_IDENT_Y, ROW_IDENT_Z));
        send_box(build_box('0, 16'd1, '0, '0, '0, '0, ROW_IDENT_X, ROW_IDENT_Y, ROW_IDENT_Z));
        send_box(build_box('0, '0, 16'd1, '0, '0, '0, ROW_IDENT_X, ROW_IDENT_Y, ROW_IDENT_Z));
        send_box(build_box(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000,
                           rand_word(), rand_word(), rand_word()));
        send_box(make_box());

        // Left plane x >= 0 and right plane x <= 1: a touching box has distance zero.
        drain_results();
        write_plane(fbc_pkg::REG_PLANE_LEFT,   pack_lanes(16'h0100, '0, '0, '0));
        write_plane(fbc_pkg::REG_PLANE_RIGHT,  pack_lanes(16'hFF00, '0, '0, 16'h0100));
        write_plane(fbc_pkg::REG_PLANE_BOTTOM, '0);
        write_plane(fbc_pkg::REG_PLANE_TOP,    '0);
        write_plane(fbc_pkg::REG_PLANE_NEAR,   '0);
        write_plane(fbc_pkg::REG_PLANE_FAR,    '0);
        send_box(build_box(16'hFF00, '0, '0, '0, '0, '0,
                           ROW_IDENT_X, ROW_IDENT_Y, ROW_IDENT_Z));
        send_box(build_box(16'hFF00, '0, '0, 16'hFFFF, '0, '0,
                           ROW_IDENT_X, ROW_IDENT_Y, ROW_IDENT_Z));
        send_box(build_box(16'h0100, '0, '0, 16'h0200, '0, '0,
                           ROW_IDENT_X, ROW_IDENT_Y, ROW_IDENT_Z));
        send_box(build_box(16'h0101, '0, '0, 16'h0200, '0, '0,
                           ROW_IDENT_X, ROW_IDENT_Y, ROW_IDENT_Z));
        send_box(build_box(16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                           ROW_IDENT_X, ROW_IDENT_Y, ROW_IDENT_Z));

        // Writes past the last plane must not disturb any plane.
        drain_results();
        write_plane(fbc_pkg::CFG_IDX_W'(fbc_pkg::NUM_PLANES), rand_word());
        write_plane(fbc_pkg::CFG_IDX_W'(fbc_pkg::NUM_PLANES + 1), rand_word());
        send_box(build_box(16'hFF00, '0, '0, 16'hFFFF, '0, '0,
                           ROW_IDENT_X, ROW_IDENT_Y, ROW_IDENT_Z));

        run_random(PLANES_FRUSTUM, 1'b0);
        run_random(PLANES_FRUSTUM, 1'b1);
        run_random(PLANES_RANDOM, 1'b0);
        run_random(PLANES_EXTREME, 1'b0);
        run_random(PLANES_FRUSTUM, 1'b0);
        run_random(PLANES_ZERO, 1'b0);

        drain_results();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("frustum_box_cull_test_core regression: pass");
        end else begin
            $display("frustum_box_cull_test_core regression: fail");
        end
        $finish;
    end

endmodule
